### rtl/bmpw_pkg.sv
// Package for the BLE MIDI packet writer: operation and status codes,
// register indexes, the result entry type and MIDI byte helper functions.
// No dependencies.
`default_nettype none

package bmpw_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int MAX_RESULTS      = 5;

    localparam logic [9:0] LIMIT_MAX = 10'(MAX_PACKET_BYTES);

    // operation codes
    localparam logic [2:0] FN_MSG       = 3'd0;
    localparam logic [2:0] FN_SX_START  = 3'd1;
    localparam logic [2:0] FN_SX_END    = 3'd2;
    localparam logic [2:0] FN_SX_DATA   = 3'd3;
    localparam logic [2:0] FN_NEW_PKT   = 3'd4;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_FULL       = 3'd1;
    localparam logic [2:0] ST_BAD_STATUS = 3'd2;
    localparam logic [2:0] ST_BAD_DATA   = 3'd3;
    localparam logic [2:0] ST_ALREADY    = 3'd4;
    localparam logic [2:0] ST_NOT_SYSEX  = 3'd5;

    // register indexes
    localparam logic [1:0] REG_RS_EN    = 2'd0;
    localparam logic [1:0] REG_NOTE_OFF = 2'd1;
    localparam logic [1:0] REG_LIMIT    = 2'd2;

    localparam logic [7:0] SYSEX_START = 8'hf0;
    localparam logic [7:0] SYSEX_END   = 8'hf7;
    localparam logic [7:0] NOTE_ON     = 8'h90;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [8:0] byte_position;
        logic [2:0] op_status;
    } t_res;

    function automatic logic is_rt(input logic [7:0] s);
        return s == 8'hf8 || s == 8'hfa || s == 8'hfb || s == 8'hfc ||
               s == 8'hfe || s == 8'hff;
    endfunction

    function automatic logic is_common(input logic [7:0] s);
        return s == 8'hf1 || s == 8'hf2 || s == 8'hf3 || s == 8'hf6;
    endfunction

    function automatic logic is_chan(input logic [7:0] s);
        return s[7] && (s[6:4] != 3'b111);
    endfunction

    // message length in bytes including status, 0 for an unknown status
    function automatic logic [1:0] msg_len(input logic [7:0] s);
        logic [1:0] len;
        len = 2'd0;
        if (s[7:4] == 4'hc || s[7:4] == 4'hd) begin
            len = 2'd2;
        end else if (is_chan(s)) begin
            len = 2'd3;
        end else if (is_rt(s) || s == 8'hf6) begin
            len = 2'd1;
        end else if (s == 8'hf1 || s == 8'hf3) begin
            len = 2'd2;
        end else if (s == 8'hf2) begin
            len = 2'd3;
        end
        return len;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [15:0] t);
        return {2'b10, t[12:7]};
    endfunction

    function automatic logic [7:0] ts_byte(input logic [15:0] t);
        return {1'b1, t[6:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/ble_midi_packet_writer_top.sv
// BLE MIDI packet writer: results are registered and appear in the cycle after an item is
// accepted; an item yields one to five results, one per cycle while i_ready is high, and
// holds the output until its last result is taken. The next item is accepted during the
// handshake of the previous item's last result, so single-result items flow at one per
// cycle while i_ready stays high. Packet encoding is one registered pass. Synchronous
// active-low reset clears packet state and the result queue and loads the register
// defaults (running status off, rewrite off, limit 20). Depends on bmpw_pkg.
`default_nettype none

module ble_midi_packet_writer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_func,
    input  wire logic [7:0]  i_status_in,
    input  wire logic [7:0]  i_first_data,
    input  wire logic [7:0]  i_second_data,
    input  wire logic [15:0] i_stamp,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic [8:0]       o_byte_position,
    output logic [2:0]       o_op_status,
    output logic             o_last_result
);
    import bmpw_pkg::*;

    // config registers
    logic       r_rs_en;
    logic       r_note_off;
    logic [9:0] r_limit;

    // packet state
    logic [9:0]  r_fill, n_fill;
    logic [7:0]  r_rs, n_rs;
    logic [7:0]  r_last_st, n_last_st;
    logic [15:0] r_last_stamp, n_last_stamp;
    logic        r_in_sysex, n_in_sysex;

    // result queue, entry 0 is presented
    t_res       r_res [MAX_RESULTS];
    t_res       n_res [MAX_RESULTS];
    logic [2:0] r_cnt, n_cnt;

    logic in_acc, out_acc, cfg_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_valid = (r_cnt != 3'd0);
    assign o_ready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign o_out_byte      = r_res[0].out_byte;
    assign o_byte_valid    = r_res[0].byte_valid;
    assign o_byte_position = r_res[0].byte_position;
    assign o_op_status     = r_res[0].op_status;
    assign o_last_result   = (r_cnt == 3'd1);

    always_comb begin
        unique case (paddr[3:2])
            REG_RS_EN:    prdata = {31'd0, r_rs_en};
            REG_NOTE_OFF: prdata = {31'd0, r_note_off};
            REG_LIMIT:    prdata = {22'd0, r_limit};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_en    <= 1'b0;
            r_note_off <= 1'b0;
            r_limit    <= 10'd20;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_RS_EN:    r_rs_en    <= pwdata[0];
                REG_NOTE_OFF: r_note_off <= pwdata[0];
                REG_LIMIT:    r_limit    <= pwdata[9:0];
                default:      ;
            endcase
        end
    end

    // ---- encoding of one item ----
    logic [9:0] lim, room;
    logic       fill_zero;
    logic [7:0] hdr, tsb;
    logic [4:0] c_en;
    logic [7:0] c_byte [MAX_RESULTS];
    logic       sole, tail_full, chk_room, clr;
    logic [2:0] sole_code;
    logic [2:0] nb, k;
    logic [7:0] s2, d1b, t_rs, t_last_st;
    logic [15:0] t_last_stamp;
    logic       t_in_sysex, upd_msg, is_rs, skip_ts;
    logic [1:0] len;

    assign lim       = (r_limit > LIMIT_MAX) ? LIMIT_MAX : r_limit;
    assign room      = (r_fill < lim) ? lim - r_fill : 10'd0;
    assign fill_zero = (r_fill == 10'd0);
    assign hdr       = hdr_byte(i_stamp);
    assign tsb       = ts_byte(i_stamp);

    always_comb begin
        c_en         = '0;
        for (int i = 0; i < MAX_RESULTS; i++) c_byte[i] = 8'd0;
        sole         = 1'b0;
        sole_code    = ST_OK;
        tail_full    = 1'b0;
        chk_room     = 1'b1;
        clr          = 1'b0;
        upd_msg      = 1'b0;
        t_rs         = r_rs;
        t_last_st    = r_last_st;
        t_last_stamp = r_last_stamp;
        t_in_sysex   = r_in_sysex;
        len          = msg_len(i_status_in);
        s2           = i_status_in;
        d1b          = i_second_data;
        is_rs        = 1'b0;
        skip_ts      = 1'b0;

        case (i_func)
            FN_MSG: begin
                if (r_in_sysex) begin
                    // real-time inside sysex: stamp and status, never a header
                    if (!is_rt(i_status_in)) begin
                        sole      = 1'b1;
                        sole_code = ST_BAD_STATUS;
                    end else begin
                        c_en[1]   = 1'b1;
                        c_byte[1] = tsb;
                        c_en[2]   = 1'b1;
                        c_byte[2] = i_status_in;
                    end
                end else if (len == 2'd0) begin
                    sole      = 1'b1;
                    sole_code = ST_BAD_STATUS;
                end else if (i_first_data[7] || i_second_data[7]) begin
                    sole      = 1'b1;
                    sole_code = ST_BAD_DATA;
                end else begin
                    upd_msg = 1'b1;
                    if (!r_rs_en) begin
                        t_rs = 8'd0;
                    end else if (is_chan(i_status_in)) begin
                        if (i_status_in[7:4] == 4'h8 && r_note_off) begin
                            s2  = NOTE_ON | {4'd0, i_status_in[3:0]};
                            d1b = 8'd0;
                        end
                        t_rs = s2;
                    end else if (!is_rt(i_status_in) && !is_common(i_status_in)) begin
                        t_rs = 8'd0;
                    end
                    is_rs   = (s2 == r_rs);
                    skip_ts = is_rs && (i_stamp == r_last_stamp) && is_chan(s2) &&
                              !(is_common(r_last_st) || is_rt(r_last_st));
                    c_en[0]   = fill_zero;
                    c_byte[0] = hdr;
                    c_en[1]   = !skip_ts;
                    c_byte[1] = tsb;
                    c_en[2]   = !(is_rs && is_chan(s2));
                    c_byte[2] = s2;
                    c_en[3]   = (len >= 2'd2);
                    c_byte[3] = i_first_data;
                    c_en[4]   = (len == 2'd3);
                    c_byte[4] = d1b;
                    t_last_st    = s2;
                    t_last_stamp = i_stamp;
                end
            end
            FN_SX_START: begin
                if (r_in_sysex) begin
                    sole      = 1'b1;
                    sole_code = ST_ALREADY;
                end else begin
                    c_en[0]    = fill_zero;
                    c_byte[0]  = hdr;
                    c_en[1]    = 1'b1;
                    c_byte[1]  = tsb;
                    c_en[2]    = 1'b1;
                    c_byte[2]  = SYSEX_START;
                    t_in_sysex = 1'b1;
                    t_rs       = 8'd0;
                end
            end
            FN_SX_END: begin
                if (!r_in_sysex) begin
                    sole      = 1'b1;
                    sole_code = ST_NOT_SYSEX;
                end else begin
                    c_en[0]    = fill_zero;
                    c_byte[0]  = hdr;
                    c_en[1]    = 1'b1;
                    c_byte[1]  = tsb;
                    c_en[2]    = 1'b1;
                    c_byte[2]  = SYSEX_END;
                    t_in_sysex = 1'b0;
                end
            end
            FN_SX_DATA: begin
                chk_room = 1'b0;
                // an empty packet takes data even with no open sysex
                if (!r_in_sysex && !fill_zero) begin
                    sole      = 1'b1;
                    sole_code = ST_NOT_SYSEX;
                end else if (i_first_data[7]) begin
                    sole      = 1'b1;
                    sole_code = ST_BAD_DATA;
                end else if (fill_zero && room == 10'd0) begin
                    sole      = 1'b1;
                    sole_code = ST_FULL;
                end else begin
                    c_en[0]   = fill_zero;
                    c_byte[0] = hdr;
                    c_en[3]   = (room >= (fill_zero ? 10'd2 : 10'd1));
                    c_byte[3] = i_first_data;
                    tail_full = !c_en[3];
                end
            end
            FN_NEW_PKT: begin
                sole = 1'b1;
                clr  = 1'b1;
            end
            default: begin
                sole      = 1'b1;
                sole_code = ST_BAD_STATUS;
            end
        endcase

        nb = 3'($countones(c_en));
        if (!sole && chk_room && room < {7'd0, nb}) begin
            sole      = 1'b1;
            sole_code = ST_FULL;
        end

        // pack enabled bytes into consecutive result slots
        for (int i = 0; i < MAX_RESULTS; i++) n_res[i] = '0;
        k = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (c_en[i]) begin
                n_res[k].out_byte      = c_byte[i];
                n_res[k].byte_valid    = 1'b1;
                n_res[k].byte_position = r_fill[8:0] + {6'd0, k};
                n_res[k].op_status     = ST_OK;
                k = k + 3'd1;
            end
        end
        if (tail_full) begin
            n_res[k].op_status = ST_FULL;
        end
        n_cnt = k + {2'd0, tail_full};
        if (sole) begin
            for (int i = 0; i < MAX_RESULTS; i++) n_res[i] = '0;
            n_res[0].op_status = sole_code;
            n_cnt              = 3'd1;
        end

        n_fill       = r_fill;
        n_rs         = r_rs;
        n_last_st    = r_last_st;
        n_last_stamp = r_last_stamp;
        n_in_sysex   = r_in_sysex;
        if (clr) begin
            n_fill       = 10'd0;
            n_rs         = 8'd0;
            n_last_st    = 8'd0;
            n_last_stamp = 16'd0;
        end else if (!sole) begin
            n_fill     = r_fill + {7'd0, nb};
            n_in_sysex = t_in_sysex;
            n_rs       = t_rs;
            if (upd_msg) begin
                n_last_st    = t_last_st;
                n_last_stamp = t_last_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= 10'd0;
            r_rs         <= 8'd0;
            r_last_st    <= 8'd0;
            r_last_stamp <= 16'd0;
            r_in_sysex   <= 1'b0;
        end else if (in_acc) begin
            r_fill       <= n_fill;
            r_rs         <= n_rs;
            r_last_st    <= n_last_st;
            r_last_stamp <= n_last_stamp;
            r_in_sysex   <= n_in_sysex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (in_acc) begin
            r_cnt <= n_cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < MAX_RESULTS; i++) r_res[i] <= n_res[i];
        end else if (out_acc) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) r_res[i] <= r_res[i + 1];
        end
    end

    // ---- assertions ----
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_valid)
        else $error("accepted word produced no result");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(MAX_RESULTS))
        else $error("result queue count out of range");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last_result)
        else $error("status-only result is not the last one");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_op_status == ST_OK))
        else $error("appended byte carries an error status");

    a_new_pkt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == FN_NEW_PKT) |=> (r_fill == 10'd0 && r_rs == 8'd0))
        else $error("new packet did not clear the fill level");

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for the BLE MIDI packet writer: directed and random words checked
// against an in-bench packet encoder, with APB register setup between phases.
// Depends on bmpw_pkg and ble_midi_packet_writer_top.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmpw_pkg::*;

    typedef enum logic [1:0] {KIND_OTHER, KIND_CHAN, KIND_COMMON, KIND_RT} t_midi_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [8:0] byte_position;
        logic [2:0] op_status;
        logic       last_result;
    } t_pkt_result;

    // func code with no operation behind it
    localparam logic [2:0] FN_RESERVED = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [7:0]  i_status_in = '0;
    logic [7:0]  i_first_data = '0;
    logic [7:0]  i_second_data = '0;
    logic [15:0] i_stamp = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic [8:0]  o_byte_position;
    logic [2:0]  o_op_status;
    logic        o_last_result;

    // encoder state and register copies
    logic [9:0]  pkt_fill = '0;
    logic [7:0]  run_status = '0;
    logic [7:0]  prev_status = '0;
    logic [15:0] prev_stamp = '0;
    logic        sysex_open = 1'b0;
    logic        cfg_rs_en = 1'b0;
    logic        cfg_note_rw = 1'b0;
    logic [9:0]  cfg_limit = 10'd20;

    t_pkt_result pending_bytes[$];
    t_pkt_result got_res, want_res;
    int          fail_count = 0;
    int          send_idle_pct = 13;
    int          recv_idle_pct = 86;
    int          words_sent = 0;
    logic [15:0] cur_stamp = '0;
    logic [7:0]  last_chan = '0;

    ble_midi_packet_writer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_status_in     (i_status_in),
        .i_first_data    (i_first_data),
        .i_second_data   (i_second_data),
        .i_stamp         (i_stamp),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_byte_position (o_byte_position),
        .o_op_status     (o_op_status),
        .o_last_result   (o_last_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic t_midi_kind kind_of(input logic [7:0] s);
        t_midi_kind k;
        k = KIND_OTHER;
        if (s[7] && s[6:4] != 3'b111) begin
            k = KIND_CHAN;
        end else begin
            case (s)
                8'hf1, 8'hf2, 8'hf3, 8'hf6: k = KIND_COMMON;
                8'hf8, 8'hfa, 8'hfb, 8'hfc, 8'hfe, 8'hff: k = KIND_RT;
                default: k = KIND_OTHER;
            endcase
        end
        return k;
    endfunction

    function automatic logic [9:0] bytes_free();
        logic [9:0] lim;
        lim = (cfg_limit > LIMIT_MAX) ? LIMIT_MAX : cfg_limit;
        return (pkt_fill < lim) ? lim - pkt_fill : 10'd0;
    endfunction

    function automatic void push_res(input logic [7:0] b, input logic v, input logic [8:0] pos,
                                     input logic [2:0] st, input logic last);
        t_pkt_result r;
        r.out_byte = b;
        r.byte_valid = v;
        r.byte_position = pos;
        r.op_status = st;
        r.last_result = last;
        pending_bytes.push_back(r);
    endfunction

    function automatic void status_only(input logic [2:0] st);
        push_res(8'h00, 1'b0, 9'd0, st, 1'b1);
    endfunction

    function automatic void append_seq(input logic [4:0][7:0] seq, input int n);
        int i;
        for (i = 0; i < n; i++) begin
            push_res(seq[i], 1'b1, pkt_fill[8:0], ST_OK, i == n - 1);
            pkt_fill++;
        end
    endfunction

    // expected packet bytes for one accepted word; updates the encoder state
    function automatic void encode_word(input logic [2:0] func, input logic [7:0] status,
                                        input logic [7:0] d1, input logic [7:0] d2,
                                        input logic [15:0] stamp);
        logic [7:0]      hdr, tsb, s, dat2, next_rs;
        logic [4:0][7:0] seq;
        t_midi_kind      kind, prev_kind;
        int              len, n;
        logic            repeat_st, skip_stamp;
        hdr = {2'b10, stamp[12:7]};
        tsb = {1'b1, stamp[6:0]};
        s = status;
        dat2 = d2;
        n = 0;
        seq = '0;
        kind = kind_of(s);
        prev_kind = kind_of(prev_status);
        case (func)
            FN_MSG: begin
                if (sysex_open) begin
                    // only real-time may interleave with sysex, and it gets no header
                    if (kind != KIND_RT) begin
                        status_only(ST_BAD_STATUS);
                    end else if (bytes_free() < 2) begin
                        status_only(ST_FULL);
                    end else begin
                        seq[0] = tsb;
                        seq[1] = s;
                        append_seq(seq, 2);
                    end
                end else begin
                    case (kind)
                        KIND_CHAN: len = (s[7:5] == 3'b110) ? 2 : 3;
                        KIND_COMMON: len = (s == 8'hf6) ? 1 : ((s == 8'hf2) ? 3 : 2);
                        KIND_RT: len = 1;
                        default: len = 0;
                    endcase
                    if (len == 0) begin
                        status_only(ST_BAD_STATUS);
                    end else if (d1[7] || d2[7]) begin
                        status_only(ST_BAD_DATA);
                    end else begin
                        next_rs = run_status;
                        if (!cfg_rs_en) begin
                            next_rs = '0;
                        end else if (kind == KIND_CHAN) begin
                            if (s[7:4] == 4'h8 && cfg_note_rw) begin
                                s = NOTE_ON | {4'h0, s[3:0]};
                                dat2 = '0;
                            end
                            next_rs = s;
                        end
                        if (pkt_fill == 0) begin
                            seq[n] = hdr;
                            n++;
                        end
                        repeat_st = (s == run_status);
                        skip_stamp = repeat_st && stamp == prev_stamp && kind == KIND_CHAN &&
                                     prev_kind != KIND_COMMON && prev_kind != KIND_RT;
                        if (!skip_stamp) begin
                            seq[n] = tsb;
                            n++;
                        end
                        if (!(repeat_st && kind == KIND_CHAN)) begin
                            seq[n] = s;
                            n++;
                        end
                        if (len > 1) begin
                            seq[n] = d1;
                            n++;
                        end
                        if (len > 2) begin
                            seq[n] = dat2;
                            n++;
                        end
                        if (bytes_free() < n) begin
                            status_only(ST_FULL);
                        end else begin
                            prev_status = s;
                            run_status = next_rs;
                            prev_stamp = stamp;
                            append_seq(seq, n);
                        end
                    end
                end
            end
            FN_SX_START, FN_SX_END: begin
                if (func == FN_SX_START && sysex_open) begin
                    status_only(ST_ALREADY);
                end else if (func == FN_SX_END && !sysex_open) begin
                    status_only(ST_NOT_SYSEX);
                end else begin
                    if (pkt_fill == 0) begin
                        seq[n] = hdr;
                        n++;
                    end
                    seq[n] = tsb;
                    n++;
                    seq[n] = (func == FN_SX_START) ? SYSEX_START : SYSEX_END;
                    n++;
                    if (bytes_free() < n) begin
                        status_only(ST_FULL);
                    end else begin
                        append_seq(seq, n);
                        sysex_open = (func == FN_SX_START);
                        if (sysex_open) begin
                            run_status = '0;
                        end
                    end
                end
            end
            FN_SX_DATA: begin
                // an empty packet takes a data byte even with no sysex open
                if (!sysex_open && pkt_fill != 0) begin
                    status_only(ST_NOT_SYSEX);
                end else if (d1[7]) begin
                    status_only(ST_BAD_DATA);
                end else if (pkt_fill == 0 && bytes_free() == 0) begin
                    status_only(ST_FULL);
                end else begin
                    if (pkt_fill == 0) begin
                        push_res(hdr, 1'b1, pkt_fill[8:0], ST_OK, 1'b0);
                        pkt_fill++;
                    end
                    if (bytes_free() != 0) begin
                        seq[0] = d1;
                        append_seq(seq, 1);
                    end else begin
                        status_only(ST_FULL);
                    end
                end
            end
            FN_NEW_PKT: begin
                pkt_fill = '0;
                prev_stamp = '0;
                run_status = '0;
                prev_status = '0;
                status_only(ST_OK);
            end
            default: status_only(ST_BAD_STATUS);
        endcase
    endfunction

    function automatic logic [7:0] pick_system(input logic rt_only);
        int k;
        logic [7:0] s;
        k = rt_only ? $urandom_range(9, 4) : $urandom_range(9, 0);
        case (k)
            0: s = 8'hf1;
            1: s = 8'hf2;
            2: s = 8'hf3;
            3: s = 8'hf6;
            4: s = 8'hf8;
            5: s = 8'hfa;
            6: s = 8'hfb;
            7: s = 8'hfc;
            8: s = 8'hfe;
            default: s = 8'hff;
        endcase
        return s;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            got_res = {o_out_byte, o_byte_valid, o_byte_position, o_op_status, o_last_result};
            if (pending_bytes.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: byte %02h valid %0d pos %0d status %0d last %0d",
                             got_res.out_byte, got_res.byte_valid, got_res.byte_position,
                             got_res.op_status, got_res.last_result);
                end
            end else begin
                want_res = pending_bytes.pop_front();
                if (got_res !== want_res) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: want byte %02h valid %0d pos %0d status %0d last %0d",
                                 want_res.out_byte, want_res.byte_valid,
                                 want_res.byte_position, want_res.op_status,
                                 want_res.last_result);
                        $display("          got  byte %02h valid %0d pos %0d status %0d last %0d",
                                 got_res.out_byte, got_res.byte_valid, got_res.byte_position,
                                 got_res.op_status, got_res.last_result);
                    end
                end
            end
        end
    end

    task automatic send_word(input logic [2:0] func, input logic [7:0] status,
                             input logic [7:0] d1, input logic [7:0] d2,
                             input logic [15:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_status_in <= status;
        i_first_data <= d1;
        i_second_data <= d2;
        i_stamp <= stamp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_word(func, status, d1, d2, stamp);
        words_sent++;
    endtask

    // hold off input until every outstanding byte has come back
    task automatic drain_and_pause();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RS_EN: cfg_rs_en = val[0];
            REG_NOTE_OFF: cfg_note_rw = val[0];
            REG_LIMIT: cfg_limit = val[9:0];
            default: ;
        endcase
    endtask

    task automatic test_message_kinds();
        send_word(FN_MSG, 8'h90, 8'h3c, 8'h7f, 16'hffff);
        send_word(FN_MSG, 8'hc5, 8'h00, 8'h00, 16'h0000);
        send_word(FN_MSG, 8'hf8, 8'h00, 8'h00, 16'h1234);
        send_word(FN_MSG, 8'hf2, 8'h7f, 8'h7f, 16'h0080);
        send_word(FN_MSG, 8'hf4, 8'h00, 8'h00, 16'h0001);
        send_word(FN_MSG, 8'h80, 8'h80, 8'h00, 16'h0001);
        send_word(FN_MSG, 8'hb0, 8'h01, 8'hff, 16'h0001);
        send_word(FN_MSG, 8'hf6, 8'h00, 8'h00, 16'h0002);
        send_word(FN_MSG, 8'he0, 8'h00, 8'h40, 16'h0003);
        send_word(FN_MSG, 8'hf8, 8'h00, 8'h00, 16'h0003);   // packet now full
        send_word(FN_RESERVED, 8'h90, 8'h00, 8'h00, 16'h0000);
        send_word(FN_NEW_PKT, 8'h00, 8'h00, 8'h00, 16'h0000);
    endtask

    task automatic test_sysex_rules();
        send_word(FN_SX_DATA, 8'h00, 8'h11, 8'hff, 16'h0040);
        send_word(FN_SX_DATA, 8'h00, 8'h12, 8'h00, 16'h0040);
        send_word(FN_SX_END, 8'h00, 8'h00, 8'h00, 16'h0041);
        send_word(FN_SX_START, 8'h00, 8'h00, 8'h00, 16'h0042);
        send_word(FN_SX_START, 8'h00, 8'h00, 8'h00, 16'h0042);
        send_word(FN_SX_DATA, 8'h00, 8'h80, 8'h00, 16'h0043);
        send_word(FN_MSG, 8'hfe, 8'h00, 8'h00, 16'h0044);
        send_word(FN_MSG, 8'h90, 8'h10, 8'h10, 16'h0044);
        send_word(FN_SX_END, 8'h00, 8'h00, 8'h00, 16'h0045);
    endtask

    task automatic test_running_status();
        drain_and_pause();
        write_reg(REG_RS_EN, 32'd1);
        write_reg(REG_NOTE_OFF, 32'd1);
        send_word(FN_NEW_PKT, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_word(FN_MSG, 8'h93, 8'h40, 8'h50, 16'd100);
        send_word(FN_MSG, 8'h83, 8'h40, 8'h22, 16'd100);   // becomes note on, vel 0
        send_word(FN_MSG, 8'h93, 8'h41, 8'h10, 16'd101);
        send_word(FN_MSG, 8'hf8, 8'h00, 8'h00, 16'd101);
        send_word(FN_MSG, 8'h93, 8'h42, 8'h10, 16'd101);   // stamp back after real-time
    endtask

    task automatic test_packet_limits();
        send_word(FN_NEW_PKT, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_word(FN_MSG, 8'h90, 8'h01, 8'h02, 16'h0005);
        drain_and_pause();
        write_reg(REG_LIMIT, 32'd3);                         // limit now below fill
        send_word(FN_MSG, 8'hf8, 8'h00, 8'h00, 16'h0006);
        drain_and_pause();
        write_reg(REG_LIMIT, 32'd1);
        send_word(FN_NEW_PKT, 8'h00, 8'h00, 8'h00, 16'h0000);
        send_word(FN_SX_DATA, 8'h00, 8'h05, 8'h00, 16'h0007);
        send_word(FN_SX_START, 8'h00, 8'h00, 8'h00, 16'h0008);
    endtask

    task automatic random_burst();
        int pick, n, i;
        if ($urandom_range(9) == 0) begin
            cur_stamp = 16'($urandom);
        end else begin
            cur_stamp = cur_stamp + 16'($urandom_range(2, 0));
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            if (last_chan == 0 || $urandom_range(1) == 0) begin
                last_chan = 8'($urandom_range(8'hef, 8'h80));
            end
            send_word(FN_MSG, last_chan, 8'($urandom_range(127, 0)),
                      8'($urandom_range(127, 0)), cur_stamp);
        end else if (pick < 45) begin
            send_word(FN_MSG, pick_system(1'b0), 8'($urandom_range(127, 0)),
                      8'($urandom_range(127, 0)), cur_stamp);
        end else if (pick < 65) begin
            send_word(FN_SX_START, 8'($urandom), 8'($urandom), 8'($urandom), cur_stamp);
            n = $urandom_range(4, 0);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(9))
                    0, 1: send_word(FN_MSG, pick_system(1'b1), 8'($urandom), 8'($urandom),
                                    cur_stamp);
                    2: send_word(FN_MSG, 8'($urandom), 8'($urandom), 8'($urandom), cur_stamp);
                    default: send_word(FN_SX_DATA, 8'($urandom), 8'($urandom_range(127, 0)),
                                       8'($urandom), cur_stamp);
                endcase
            end
            // now and then leave the sysex open
            if ($urandom_range(9) != 0) begin
                send_word(FN_SX_END, 8'($urandom), 8'($urandom), 8'($urandom), cur_stamp);
            end
        end else if (pick < 75) begin
            send_word(FN_NEW_PKT, 8'($urandom), 8'($urandom), 8'($urandom), cur_stamp);
        end else begin
            send_word(3'($urandom_range(7, 0)), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom));
        end
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic rs, input logic noff,
                                       input logic [9:0] limit, input int count);
        drain_and_pause();
        write_reg(REG_RS_EN, {31'd0, rs});
        write_reg(REG_NOTE_OFF, {31'd0, noff});
        write_reg(REG_LIMIT, {22'd0, limit});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        words_sent = 0;
        while (words_sent < count) random_burst();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_message_kinds();
        test_sysex_rules();
        test_running_status();
        test_packet_limits();
        test_random_traffic(13, 86, 1'b1, 1'b1, 10'd20, 120);
        test_random_traffic(86, 13, 1'b1, 1'b0, 10'd512, 120);
        test_random_traffic(0, 0, 1'b0, 1'b1, 10'($urandom_range(40, 2)), 120);
        drain_and_pause();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
